// ===== rtl/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// aat_pkg
// Shared widths, register codes, control struct and the rounding function
// for the affine bounding box transform.
// ----------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RowW     = 3 * CoefW;
  localparam int unsigned SumW     = CoordW + 1;
  localparam int unsigned MagW     = CoefW + 2;
  localparam int unsigned ProdAW   = CoefW + SumW;
  localparam int unsigned ProdBW   = MagW + SumW;
  localparam int unsigned AccW     = 56;
  localparam int unsigned FracDrop = 13;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned BoxW     = 2 * NumAxes * CoordW;
  localparam int unsigned NumStg   = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = RowW;

  localparam logic [CfgIdxW-1:0] RegRow0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegShiftX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegShiftY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegShiftZ = 3'd5;

  localparam logic [RowW-1:0] Row0Reset = 48'h0000_0000_1000;
  localparam logic [RowW-1:0] Row1Reset = 48'h0000_1000_0000;
  localparam logic [RowW-1:0] Row2Reset = 48'h1000_0000_0000;

  typedef struct packed {
    logic [NumStg-1:0] load;
  } ctrl_t;

  // drop fractional bits rounding half up, then clamp to 32 bits
  function automatic logic signed [CoordW-1:0] round_sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0]          r;
    logic signed [AccW-FracDrop-1:0] q;
    logic                            ovf;
    r   = v + AccW'(1 << (FracDrop - 1));
    q   = (AccW-FracDrop)'(r >>> FracDrop);
    ovf = (q[AccW-FracDrop-1:CoordW-1] != {(AccW-FracDrop-CoordW+1){q[CoordW-1]}});
    if (!ovf) begin
      round_sat = q[CoordW-1:0];
    end else if (q[AccW-FracDrop-1]) begin
      round_sat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aabb_affine_transform_top.sv =====
// ----------------------------------------------------------------------------
// aabb_affine_transform_top
// Affine transform of an axis-aligned box given by its corners, giving the
// enclosing box of the result in saturated Q16.16.
// ----------------------------------------------------------------------------
// pipeline from input accept to output valid: corner sums, products,
// row sums, centre and extent combine, round and saturate
// throughput: one item per cycle while m_axis_tready does not stall the output
// reset: asynchronous active low, empties the pipeline and loads the
// identity matrix with zero translation
`default_nettype none

module aabb_affine_transform_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  input  wire logic [aat_pkg::BoxW-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z
  output logic [aat_pkg::BoxW-1:0]           m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [aat_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [aat_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned W = aat_pkg::CoordW;

  aat_pkg::ctrl_t ctrl;

  logic [aat_pkg::RowW-1:0]   row_q [aat_pkg::NumAxes];
  logic signed [W-1:0]        shift_q [aat_pkg::NumAxes];

  logic signed [aat_pkg::SumW-1:0] s_q [aat_pkg::NumAxes];
  logic signed [aat_pkg::SumW-1:0] d_q [aat_pkg::NumAxes];
  logic signed [aat_pkg::SumW-1:0] s_d [aat_pkg::NumAxes];
  logic signed [aat_pkg::SumW-1:0] d_d [aat_pkg::NumAxes];

  logic signed [W-1:0] out_lo [aat_pkg::NumAxes];
  logic signed [W-1:0] out_hi [aat_pkg::NumAxes];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= aat_pkg::Row0Reset;
      row_q[1]   <= aat_pkg::Row1Reset;
      row_q[2]   <= aat_pkg::Row2Reset;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        aat_pkg::RegRow0:   row_q[0]   <= cfg_data_i;
        aat_pkg::RegRow1:   row_q[1]   <= cfg_data_i;
        aat_pkg::RegRow2:   row_q[2]   <= cfg_data_i;
        aat_pkg::RegShiftX: shift_q[0] <= cfg_data_i[W-1:0];
        aat_pkg::RegShiftY: shift_q[1] <= cfg_data_i[W-1:0];
        aat_pkg::RegShiftZ: shift_q[2] <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  aat_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  // doubled centre and doubled extent, exact in 33 bits
  always_comb begin
    for (int j = 0; j < aat_pkg::NumAxes; j++) begin
      logic signed [W-1:0] lo;
      logic signed [W-1:0] hi;
      lo     = s_axis_tdata[j*W +: W];
      hi     = s_axis_tdata[(j+aat_pkg::NumAxes)*W +: W];
      s_d[j] = aat_pkg::SumW'(hi) + aat_pkg::SumW'(lo);
      d_d[j] = aat_pkg::SumW'(hi) - aat_pkg::SumW'(lo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      s_q <= s_d;
      d_q <= d_d;
    end
  end

  for (genvar i = 0; i < aat_pkg::NumAxes; i++) begin : g_row
    aat_row u_row (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .s_i     (s_q),
      .d_i     (d_q),
      .coef_i  (row_q[i]),
      .shift_i (shift_q[i]),
      .lo_o    (out_lo[i]),
      .hi_o    (out_hi[i])
    );
    assign m_axis_tdata[i*W +: W]                     = out_lo[i];
    assign m_axis_tdata[(i+aat_pkg::NumAxes)*W +: W]  = out_hi[i];
  end

endmodule

`default_nettype wire

// ===== rtl/aat_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// aat_pipe_ctrl
// Valid bits and per-stage load enables; a stage takes a new item when it
// is empty or its successor moves on, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_pipe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output aat_pkg::ctrl_t     ctrl_o
);

  logic [aat_pkg::NumStg-1:0] valid_q;
  logic [aat_pkg::NumStg-1:0] valid_d;
  logic [aat_pkg::NumStg:0]   ready;

  always_comb begin
    ready[aat_pkg::NumStg] = out_ready_i;
    for (int k = aat_pkg::NumStg - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < aat_pkg::NumStg; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load = ready[aat_pkg::NumStg-1:0];
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[aat_pkg::NumStg-1];

endmodule

`default_nettype wire

// ===== rtl/aat_row.sv =====
// ----------------------------------------------------------------------------
// aat_row
// One output axis: products, row sums, centre plus or minus extent with the
// translation, then rounding and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_row (
  input  wire logic                                 clk_i,
  input  wire aat_pkg::ctrl_t                       ctrl_i,
  input  wire logic signed [aat_pkg::SumW-1:0]      s_i [aat_pkg::NumAxes],
  input  wire logic signed [aat_pkg::SumW-1:0]      d_i [aat_pkg::NumAxes],
  input  wire logic [aat_pkg::RowW-1:0]             coef_i,
  input  wire logic signed [aat_pkg::CoordW-1:0]    shift_i,
  output logic signed [aat_pkg::CoordW-1:0]         lo_o,
  output logic signed [aat_pkg::CoordW-1:0]         hi_o
);

  logic signed [aat_pkg::ProdAW-1:0] prod_a_d [aat_pkg::NumAxes];
  logic signed [aat_pkg::ProdAW-1:0] prod_a_q [aat_pkg::NumAxes];
  logic signed [aat_pkg::ProdBW-1:0] prod_b_d [aat_pkg::NumAxes];
  logic signed [aat_pkg::ProdBW-1:0] prod_b_q [aat_pkg::NumAxes];
  logic signed [aat_pkg::AccW-1:0]   sum_a_d, sum_a_q, sum_b_d, sum_b_q;
  logic signed [aat_pkg::AccW-1:0]   tsh;
  logic signed [aat_pkg::AccW-1:0]   lo_d, lo_q, hi_d, hi_q;
  logic signed [aat_pkg::CoordW-1:0] out_lo_d, out_lo_q, out_hi_d, out_hi_q;

  always_comb begin
    for (int j = 0; j < aat_pkg::NumAxes; j++) begin
      logic signed [aat_pkg::CoefW-1:0] m;
      logic [aat_pkg::CoefW:0]          mabs;
      m    = coef_i[j*aat_pkg::CoefW +: aat_pkg::CoefW];
      // most negative code keeps its full magnitude
      mabs = m[aat_pkg::CoefW-1] ? (aat_pkg::CoefW+1)'(-{1'b1, m}) : {1'b0, m};
      prod_a_d[j] = aat_pkg::ProdAW'(m * s_i[j]);
      prod_b_d[j] = aat_pkg::ProdBW'($signed({1'b0, mabs}) * d_i[j]);
    end
  end

  assign sum_a_d = aat_pkg::AccW'(prod_a_q[0]) + aat_pkg::AccW'(prod_a_q[1])
                 + aat_pkg::AccW'(prod_a_q[2]);
  assign sum_b_d = aat_pkg::AccW'(prod_b_q[0]) + aat_pkg::AccW'(prod_b_q[1])
                 + aat_pkg::AccW'(prod_b_q[2]);

  assign tsh  = aat_pkg::AccW'(shift_i) <<< aat_pkg::FracDrop;
  assign lo_d = sum_a_q - sum_b_q + tsh;
  assign hi_d = sum_a_q + sum_b_q + tsh;

  assign out_lo_d = aat_pkg::round_sat(lo_q);
  assign out_hi_d = aat_pkg::round_sat(hi_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
    if (ctrl_i.load[2]) begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
    if (ctrl_i.load[3]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (ctrl_i.load[4]) begin
      out_lo_q <= out_lo_d;
      out_hi_q <= out_hi_d;
    end
  end

  assign lo_o = out_lo_q;
  assign hi_o = out_hi_q;

endmodule

`default_nettype wire

// ===== rtl/aat_checker.sv =====
// ----------------------------------------------------------------------------
// aat_checker
// Port-level checks on the stream and configuration channels, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [aat_pkg::BoxW-1:0]      m_axis_tdata,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o
);

  // a stalled result holds its item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed under stall");

  // input backpressure only when the whole pipeline is blocked
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output free");

  // an item reaches the output when the sink keeps taking while it passes through
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("item did not arrive in time");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind aabb_affine_transform_top aat_checker u_aat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

// ===== dv/tb_aabb_affine_transform_top.sv =====
// ----------------------------------------------------------------------------
// tb_aabb_affine_transform_top
// Streams boxes through the affine box transform under a series of matrix
// and translation settings. Every accepted box is predicted with exact
// integer arithmetic (doubled centre and extent, half-up rounding,
// saturation). Each output box is checked field by field in order. Both
// stream sides stall at random, with one phase run at full rate.
// ----------------------------------------------------------------------------

module tb_aabb_affine_transform_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [aat_pkg::CoordW-1:0] coord_t;
  typedef coord_t [2*aat_pkg::NumAxes-1:0] box_t;

  localparam int unsigned NumAxes = aat_pkg::NumAxes;
  localparam int unsigned CoefW   = aat_pkg::CoefW;
  localparam int unsigned CoordW  = aat_pkg::CoordW;

  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;
  localparam logic [CoefW-1:0] CoefNegEight = 16'h8000;
  localparam logic [CoefW-1:0] CoefMaxPos   = 16'h7fff;
  localparam logic [CoefW-1:0] CoefOne      = 16'h1000;
  localparam logic [CoefW-1:0] CoefNegOne   = 16'hf000;
  localparam logic [CoefW-1:0] CoefHalf     = 16'h0800;
  localparam logic [CoefW-1:0] CoefZero     = 16'h0000;
  localparam logic [aat_pkg::CfgIdxW-1:0] RegSpare0 = 3'd6;
  localparam logic [aat_pkg::CfgIdxW-1:0] RegSpare1 = 3'd7;

  localparam string FieldName [2*NumAxes] =
    '{"out_lo_x", "out_lo_y", "out_lo_z", "out_hi_x", "out_hi_y", "out_hi_z"};

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [aat_pkg::BoxW-1:0]      s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [aat_pkg::BoxW-1:0]      m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [aat_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [aat_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  aabb_affine_transform_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // transform settings as the block should hold them
  logic [aat_pkg::RowW-1:0] mat_row [NumAxes];
  coord_t                   shift_vec [NumAxes];

  box_t boxes_todo [$];
  box_t boxes_due [$];
  logic box_taken = 1'b0;
  logic steady = 1'b0;
  int   boxes_in = 0;
  int   boxes_checked = 0;
  int   reg_writes = 0;
  int   settings_run = 0;
  int   mismatches = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic coord_t round_q16(input longint v);
    longint q;
    q = (v + 64'sd4096) >>> aat_pkg::FracDrop;
    if (q > longint'(CoordMax)) q = CoordMax;
    if (q < longint'(CoordMin)) q = CoordMin;
    return coord_t'(q);
  endfunction

  // exact centre/extent transform with 29 fractional bits per row sum
  function automatic box_t transform_box(input box_t b);
    box_t               r;
    longint             ctr2 [NumAxes];
    longint             ext2 [NumAxes];
    longint             acc_c, acc_e, m, t;
    logic signed [15:0] c;
    coord_t             lo, hi;
    for (int j = 0; j < NumAxes; j++) begin
      lo = b[j];
      hi = b[j+NumAxes];
      ctr2[j] = longint'(lo) + longint'(hi);
      ext2[j] = longint'(hi) - longint'(lo);
    end
    for (int i = 0; i < NumAxes; i++) begin
      acc_c = 0;
      acc_e = 0;
      t = shift_vec[i];
      t = t * 8192;
      for (int j = 0; j < NumAxes; j++) begin
        c = mat_row[i][CoefW*j +: CoefW];
        m = c;
        acc_c += m * ctr2[j];
        acc_e += (m < 0 ? -m : m) * ext2[j];
      end
      r[i]         = round_q16(acc_c - acc_e + t);
      r[i+NumAxes] = round_q16(acc_c + acc_e + t);
    end
    return r;
  endfunction

  // sender and receiver, both change on the falling edge
  always @(negedge clk_i) begin
    logic                     nxt_valid;
    logic [aat_pkg::BoxW-1:0] nxt_data;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    if (rst_ni && (!s_axis_tvalid || box_taken)) begin
      nxt_valid = 1'b0;
      if (boxes_todo.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
        nxt_data  = boxes_todo.pop_front();
        nxt_valid = 1'b1;
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
    m_axis_tready <= rst_ni && (steady || $urandom_range(99) >= 25);
  end

  always @(posedge clk_i) begin
    box_t got, want;
    box_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (boxes_due.size() == 0) begin
        report_mismatch($sformatf("output box %h with nothing pending", got));
      end else begin
        want = boxes_due.pop_front();
        for (int k = 0; k < 2*NumAxes; k++) begin
          if (got[k] !== want[k]) begin
            report_mismatch($sformatf("box %0d %s got %h want %h",
                                      boxes_checked, FieldName[k], got[k], want[k]));
          end
        end
        boxes_checked++;
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      boxes_due.push_back(transform_box(s_axis_tdata));
      boxes_in++;
    end
  end

  task automatic write_reg(input logic [aat_pkg::CfgIdxW-1:0] idx,
                           input logic [aat_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      aat_pkg::RegRow0:   mat_row[0] = val;
      aat_pkg::RegRow1:   mat_row[1] = val;
      aat_pkg::RegRow2:   mat_row[2] = val;
      aat_pkg::RegShiftX: shift_vec[0] = val[CoordW-1:0];
      aat_pkg::RegShiftY: shift_vec[1] = val[CoordW-1:0];
      aat_pkg::RegShiftZ: shift_vec[2] = val[CoordW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_all_done();
    int guard;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while ((boxes_todo.size() != 0 || s_axis_tvalid || boxes_due.size() != 0)
               && guard < 50000);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic box_t mk_box(input coord_t lx, ly, lz, hx, hy, hz);
    box_t r;
    r[0] = lx;
    r[1] = ly;
    r[2] = lz;
    r[3] = hx;
    r[4] = hy;
    r[5] = hz;
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0, 1:    return coord_t'($urandom);
      2:       return coord_t'($urandom_range(2097151)) - 32'sd1048576;
      3:       return $urandom_range(1) ? CoordMax : CoordMin;
      default: return coord_t'($urandom_range(33554431)) - 32'sd16777216;
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t   r;
    coord_t a, b;
    for (int j = 0; j < NumAxes; j++) begin
      a = rand_coord();
      if ($urandom_range(2) == 0) b = a + coord_t'($urandom_range(1048575));
      else b = rand_coord();
      // mostly well-formed boxes, a few inverted ones
      if ((a > b) != ($urandom_range(9) == 0)) begin
        r[j] = b;
        r[j+NumAxes] = a;
      end else begin
        r[j] = a;
        r[j+NumAxes] = b;
      end
    end
    return r;
  endfunction

  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(4))
      0: return CoefW'($urandom);
      1: begin
        case ($urandom_range(4))
          0:       return CoefNegEight;
          1:       return CoefMaxPos;
          2:       return CoefOne;
          3:       return CoefNegOne;
          default: return CoefZero;
        endcase
      end
      default: return CoefW'($urandom_range(16383)) - 16'h2000;
    endcase
  endfunction

  function automatic logic [aat_pkg::CfgDataW-1:0] rand_shift();
    logic [aat_pkg::CfgDataW-1:0] v;
    v = {16'($urandom), 32'($urandom)};
    case ($urandom_range(5))
      0:       v[CoordW-1:0] = CoordMax;
      1:       v[CoordW-1:0] = CoordMin;
      2:       v[CoordW-1:0] = 32'($urandom_range(2097151)) - 32'd1048576;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    mat_row[0]   = aat_pkg::Row0Reset;
    mat_row[1]   = aat_pkg::Row1Reset;
    mat_row[2]   = aat_pkg::Row2Reset;
    shift_vec[0] = '0;
    shift_vec[1] = '0;
    shift_vec[2] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // identity after reset: extremes, inverted and degenerate boxes
    settings_run++;
    boxes_todo.push_back(mk_box(0, 0, 0, 0, 0, 0));
    boxes_todo.push_back(mk_box(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax));
    boxes_todo.push_back(mk_box(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin));
    boxes_todo.push_back(mk_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    boxes_todo.push_back(mk_box(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin));
    boxes_todo.push_back(mk_box(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                                32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa));
    boxes_todo.push_back(mk_box(-32'sd65536, -32'sd3, 32'sd7, 32'sd65536, 32'sd5, -32'sd9));
    wait_all_done();

    // coefficient -8.0 and the largest positive one, translation at the limits
    settings_run++;
    write_reg(aat_pkg::RegRow0, {CoefMaxPos, CoefNegEight, CoefMaxPos});
    write_reg(aat_pkg::RegRow1, {CoefNegEight, CoefNegEight, CoefNegEight});
    write_reg(aat_pkg::RegRow2, {CoefMaxPos, CoefMaxPos, CoefMaxPos});
    write_reg(aat_pkg::RegShiftX, {16'hffff, CoordMax});
    write_reg(aat_pkg::RegShiftY, {16'h0000, CoordMin});
    write_reg(aat_pkg::RegShiftZ, {16'h5a5a, 32'hffff_ffff});
    boxes_todo.push_back(mk_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    boxes_todo.push_back(mk_box(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin));
    boxes_todo.push_back(mk_box(0, 0, 0, 0, 0, 0));
    boxes_todo.push_back(mk_box(-32'sd1, -32'sd1, -32'sd1, 32'sd1, 32'sd1, 32'sd1));
    boxes_todo.push_back(mk_box(32'sd65536, -32'sd65536, 32'sd1, 32'sd131072, 32'sd0, 32'sd2));
    boxes_todo.push_back(mk_box(CoordMax, CoordMin, 0, CoordMax, CoordMin, 0));
    wait_all_done();

    // half coefficients put row sums exactly on a rounding midpoint;
    // writes to unused indexes must change nothing
    settings_run++;
    write_reg(RegSpare0, '1);
    write_reg(aat_pkg::RegRow0, {CoefZero, CoefZero, CoefHalf});
    write_reg(aat_pkg::RegRow1, {CoefZero, CoefHalf, CoefZero});
    write_reg(aat_pkg::RegRow2, {CoefHalf, CoefZero, CoefZero});
    write_reg(RegSpare1, {16'h1234, 32'h8765_4321});
    write_reg(aat_pkg::RegShiftX, '0);
    write_reg(aat_pkg::RegShiftY, {16'hffff, 32'h0000_0001});
    write_reg(aat_pkg::RegShiftZ, {16'h0000, 32'hffff_ffff});
    boxes_todo.push_back(mk_box(32'sd1, 32'sd1, 32'sd1, 32'sd2, 32'sd2, 32'sd2));
    boxes_todo.push_back(mk_box(-32'sd3, -32'sd3, -32'sd3, 32'sd0, 32'sd0, 32'sd0));
    boxes_todo.push_back(mk_box(-32'sd1, 32'sd0, 32'sd1, -32'sd2, 32'sd3, -32'sd4));
    boxes_todo.push_back(mk_box(32'sd5, -32'sd7, 32'sd9, 32'sd2, -32'sd4, 32'sd6));
    boxes_todo.push_back(mk_box(CoordMin, CoordMax, CoordMin, CoordMax, CoordMax, CoordMin));
    wait_all_done();

    // random settings, random boxes
    for (int p = 0; p < 8; p++) begin
      settings_run++;
      if (p == 3) steady = 1'b1;
      if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? RegSpare0 : RegSpare1,
                                            {16'($urandom), 32'($urandom)});
      write_reg(aat_pkg::RegRow0, {rand_coef(), rand_coef(), rand_coef()});
      write_reg(aat_pkg::RegRow1, {rand_coef(), rand_coef(), rand_coef()});
      write_reg(aat_pkg::RegRow2, {rand_coef(), rand_coef(), rand_coef()});
      write_reg(aat_pkg::RegShiftX, rand_shift());
      write_reg(aat_pkg::RegShiftY, rand_shift());
      write_reg(aat_pkg::RegShiftZ, rand_shift());
      for (int n = 0; n < 250; n++) boxes_todo.push_back(rand_box());
      wait_all_done();
      steady = 1'b0;
    end

    if (boxes_due.size() != 0) begin
      report_mismatch($sformatf("%0d boxes never came out", boxes_due.size()));
    end
    $display("checked %0d of %0d boxes under %0d transform settings", boxes_checked,
             boxes_in, settings_run);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
